### src/cdt_pkg.sv
`timescale 1ns / 1ps
package cdt_pkg;
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = COL_W + ROW_W;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int SIZE_W     = 9;
    localparam int PIX_W      = 8;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    localparam logic [PIX_W-1:0] PIX_FAR = 8'hFF;

    // phase of the per-pixel sequence
    localparam logic [3:0] PH_WRITE = 4'd3;
    localparam logic [3:0] PH_DIV0  = 4'd2;
    localparam logic [3:0] PH_DIVN  = 4'd9;
    localparam logic [3:0] PH_SWR   = 4'd10;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FWD,
        S_BWD,
        S_SCALE
    } t_state;

    function automatic logic [PIX_W-1:0] f_cand(input logic [PIX_W-1:0] x);
        f_cand = (x == PIX_FAR) ? PIX_FAR : x + 8'd1;
    endfunction

    function automatic logic [PIX_W-1:0] f_min(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
        f_min = (a < b) ? a : b;
    endfunction
endpackage

### src/chessboard_distance_transform_top.sv
`timescale 1ns / 1ps
// Image store of 256 x 256 pixels with a chessboard distance transform. A write
// returns no item; a read registers the addressed pixel, then loads it into the
// result register as its item. A run sweeps the configured region three times
// through the single read port of the store: a forward and a backward pass (per
// pixel: self and two neighbours read, then write back), then a scaling pass
// through the bit-serial divider, after which the run item appears. No item is
// accepted while a result waits.
module chessboard_distance_transform_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [cdt_pkg::SIZE_W-1:0] i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_command,
    input  logic [7:0]               i_row,
    input  logic [7:0]               i_column,
    input  logic [7:0]               i_pixel_in,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_kind,
    output logic [7:0]               o_pixel_out,
    output logic [7:0]               o_peak_distance,
    output logic                     o_status
);
    import cdt_pkg::*;

    localparam logic [SIZE_W-1:0] WIDTH_LIM  = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] HEIGHT_LIM = SIZE_W'(MAX_HEIGHT);

    logic [PIX_W-1:0] r_mem [0:DEPTH-1];
    logic [PIX_W-1:0] r_q;
    logic [ADDR_W-1:0] ra, wa;
    logic             we;
    logic [PIX_W-1:0] wd;

    t_state r_state, n_state;
    logic [SIZE_W-1:0] r_width, r_height, w_eff, h_eff;
    logic [COL_W-1:0]  r_c, w_last;
    logic [ROW_W-1:0]  r_r, h_last;
    logic [3:0]        r_ph;
    logic [PIX_W-1:0]  r_self, r_u, r_ul, r_left, r_acc, r_peak, r_quo;
    logic [15:0]       r_div;
    logic              r_zero;
    logic              r_rd_pend, r_rd_in;
    logic              r_out_valid, r_kind, r_status;
    logic [PIX_W-1:0]  r_pix;

    logic              accept, in_region, last_c, last_r, first_c, first_r, scale_end;
    logic [PIX_W-1:0]  far_n, new_f, new_b, self_init;
    logic [2:0]        div_bit;
    logic [15:0]       div_sub;

    assign w_eff  = (r_width == '0) ? SIZE_W'(1) : (r_width > WIDTH_LIM) ? WIDTH_LIM : r_width;
    assign h_eff  = (r_height == '0) ? SIZE_W'(1) :
                    (r_height > HEIGHT_LIM) ? HEIGHT_LIM : r_height;
    assign w_last = COL_W'(w_eff - SIZE_W'(1));
    assign h_last = ROW_W'(h_eff - SIZE_W'(1));
    assign in_region = ({1'b0, i_row} < h_eff) && ({1'b0, i_column} < w_eff);

    assign o_ready = (r_state == S_IDLE) && !r_rd_pend && !r_out_valid;
    assign accept  = i_valid && o_ready;

    assign last_c  = (r_c == w_last);
    assign last_r  = (r_r == h_last);
    assign first_c = (r_c == '0);
    assign first_r = (r_r == '0);

    // neighbour in r_q, masked when outside the region
    always_comb begin
        far_n = r_q;
        if (r_state == S_FWD && (first_r || last_c)) far_n = PIX_FAR;
        if (r_state == S_BWD && (last_r || first_c)) far_n = PIX_FAR;
    end

    assign self_init = (r_self == PIX_FAR) ? '0 : PIX_FAR;
    assign new_f = f_min(f_min(self_init, f_cand(r_left)),
                         f_min(f_min(f_cand(r_ul), f_cand(r_u)), f_cand(far_n)));
    assign new_b = f_min(f_min(r_self, f_cand(r_left)),
                         f_min(f_min(f_cand(r_ul), f_cand(r_u)), f_cand(far_n)));

    assign div_bit   = 3'(PH_DIVN - r_ph);
    assign div_sub   = {8'd0, r_acc} << div_bit;
    assign scale_end = (r_state == S_SCALE) && (r_ph == PH_SWR) && last_c && last_r;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept && i_command == CMD_RUN) n_state = S_FWD;
            S_FWD:   if (r_ph == PH_WRITE && last_c && last_r) n_state = S_BWD;
            S_BWD:   if (r_ph == PH_WRITE && first_c && first_r) n_state = S_SCALE;
            S_SCALE: if (scale_end) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ra = {i_row, i_column};
        we = 1'b0;
        wa = {r_r, r_c};
        wd = new_f;
        unique case (r_state)
            S_IDLE: begin
                wa = {i_row, i_column};
                wd = i_pixel_in;
                we = accept && (i_command == CMD_WRITE) && in_region;
            end
            S_FWD: begin
                ra = (r_ph == 4'd0) ? {r_r, r_c} :
                     (r_ph == 4'd1) ? {r_r - ROW_W'(1), r_c} :
                                      {r_r - ROW_W'(1), r_c + COL_W'(1)};
                we = (r_ph == PH_WRITE);
            end
            S_BWD: begin
                ra = (r_ph == 4'd0) ? {r_r, r_c} :
                     (r_ph == 4'd1) ? {r_r + ROW_W'(1), r_c} :
                                      {r_r + ROW_W'(1), r_c - COL_W'(1)};
                we = (r_ph == PH_WRITE);
                wd = new_b;
            end
            S_SCALE: begin
                ra = {r_r, r_c};
                we = (r_ph == PH_SWR);
                wd = r_zero ? '0 : r_quo;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        r_q <= r_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_width     <= WIDTH_LIM;
            r_height    <= HEIGHT_LIM;
            r_peak      <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_ph        <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_WIDTH:  r_width  <= i_cfg_data;
                    REG_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_valid && i_ready) r_out_valid <= 1'b0;
            r_rd_pend <= accept && (i_command == CMD_READ);
            if (accept) r_rd_in <= in_region;
            if (r_rd_pend) begin
                r_out_valid <= 1'b1;
                r_kind      <= 1'b0;
                r_pix       <= r_rd_in ? r_q : '0;
                r_status    <= !r_rd_in;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_ph   <= '0;
                    r_r    <= '0;
                    r_c    <= '0;
                    r_left <= PIX_FAR;
                    r_ul   <= PIX_FAR;
                    r_acc  <= '0;
                end
                S_FWD, S_BWD: begin
                    r_ph <= (r_ph == PH_WRITE) ? '0 : r_ph + 4'd1;
                    if (r_ph == 4'd1) r_self <= r_q;
                    if (r_ph == 4'd2)
                        r_u <= ((r_state == S_FWD) ? first_r : last_r) ? PIX_FAR : r_q;
                    if (r_ph == PH_WRITE) begin
                        if (r_state == S_FWD) begin
                            if (last_c) begin
                                r_left <= PIX_FAR;
                                r_ul   <= PIX_FAR;
                                r_c    <= last_r ? w_last : '0;
                                if (!last_r) r_r <= r_r + ROW_W'(1);
                            end else begin
                                r_left <= new_f;
                                r_ul   <= r_u;
                                r_c    <= r_c + COL_W'(1);
                            end
                        end else begin
                            if (new_b != PIX_FAR && new_b > r_acc) r_acc <= new_b;
                            if (first_c) begin
                                r_left <= PIX_FAR;
                                r_ul   <= PIX_FAR;
                                r_c    <= first_r ? '0 : w_last;
                                if (!first_r) r_r <= r_r - ROW_W'(1);
                            end else begin
                                r_left <= new_b;
                                r_ul   <= r_u;
                                r_c    <= r_c - COL_W'(1);
                            end
                        end
                    end
                end
                S_SCALE: begin
                    r_ph <= (r_ph == PH_SWR) ? '0 : r_ph + 4'd1;
                    if (r_ph == 4'd1) begin
                        r_div  <= {r_q, 8'd0} - {8'd0, r_q};
                        r_zero <= (r_q == PIX_FAR) || (r_acc == '0);
                        r_quo  <= '0;
                    end
                    if (r_ph >= PH_DIV0 && r_ph <= PH_DIVN && r_div >= div_sub) begin
                        r_div          <= r_div - div_sub;
                        r_quo[div_bit] <= 1'b1;
                    end
                    if (r_ph == PH_SWR) begin
                        if (last_c) begin
                            r_c <= '0;
                            r_r <= r_r + ROW_W'(1);
                        end else begin
                            r_c <= r_c + COL_W'(1);
                        end
                        if (scale_end) begin
                            r_peak      <= r_acc;
                            r_out_valid <= 1'b1;
                            r_kind      <= 1'b1;
                            r_pix       <= '0;
                            r_status    <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_kind          = r_kind;
    assign o_pixel_out     = r_pix;
    assign o_peak_distance = r_peak;
    assign o_status        = r_status;

    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !o_ready) else $error("item accepted while result waits");
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |=> r_out_valid) else $error("read item lost");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready during run");
    a_run_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind) |-> (o_pixel_out == '0 && !o_status))
        else $error("run item fields wrong");
endmodule
